// ----- sv/csvt_pkg.sv -----
// ----------------------------------------------------------------------------
// csvt_pkg: shared types and constants of the CSV tokenizer
// Holds the token kinds, the register indexes, the special characters,
// the queue entry type and the Windows-1251 upper-half table.
// ----------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

	localparam int unsigned CharW = 16;
	localparam int unsigned CfgIdxW = 2;

	typedef enum logic [1:0] {
		KIND_CHAR      = 2'd0,
		KIND_FIELD_END = 2'd1,
		KIND_ROW_END   = 2'd2
	} kind_t;

	localparam logic [CfgIdxW-1:0] REG_DELIMITER   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_CP1251_MODE = 2'd1;

	localparam logic [CharW-1:0] QUOTE_CH     = 16'h0022;
	localparam logic [CharW-1:0] CR_CH        = 16'h000D;
	localparam logic [CharW-1:0] LF_CH        = 16'h000A;
	localparam logic [CharW-1:0] DELIM_RESET  = 16'd59;

	// One classified item as it travels from front to back.
	typedef struct packed {
		logic             eot;
		logic             is_quote;
		logic             is_delim;
		logic             is_cr;
		logic             is_lf;
		logic [CharW-1:0] ch;
	} entry_t;

	// Bytes 0x80..0xFF, as in Windows-1251 but for 0x9A and 0x9C..0x9F; 0x98 and 0x9F give U+FFFD.
	localparam logic [CharW-1:0] CP1251_HI [128] = '{
		16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
		16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
		16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
		16'hFFFD, 16'h2122, 16'h045A, 16'h203A, 16'h045C, 16'h045B, 16'h045F, 16'hFFFD,
		16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
		16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
		16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
		16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
		16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
		16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
		16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
		16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
		16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
		16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
		16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
		16'h0448, 16'h0449, 16'h044A, 16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F
	};

endpackage

`default_nettype wire

// ----- sv/csvt_front.sv -----
// ----------------------------------------------------------------------------
// csvt_front: character decode and classification
// Decodes the incoming code unit and flags quote, delimiter, CR and LF.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_front
	import csvt_pkg::*;
(
	input  wire logic             op,
	input  wire logic [CharW-1:0] code,
	input  wire logic [CharW-1:0] delimiter,
	input  wire logic             cp1251_mode,
	output entry_t                entry
);

	logic [CharW-1:0] ch;

	always_comb begin
		if (!cp1251_mode) begin
			ch = code;
		end else if (!code[7]) begin
			ch = {8'h00, code[7:0]};
		end else begin
			ch = CP1251_HI[code[6:0]];
		end
	end

	always_comb begin
		entry.eot      = op;
		entry.is_quote = (ch == QUOTE_CH);
		entry.is_delim = (ch == delimiter);
		entry.is_cr    = (ch == CR_CH);
		entry.is_lf    = (ch == LF_CH);
		entry.ch       = ch;
	end

endmodule

`default_nettype wire

// ----- sv/csvt_queue.sv -----
// ----------------------------------------------------------------------------
// csvt_queue: short first-word-fall-through queue
// Decouples the classifier from the token engine.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_queue
	import csvt_pkg::*;
#(
	parameter int unsigned Depth = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t wr_entry,
	output logic        full,
	input  wire logic   pop,
	output logic        nonempty,
	output entry_t      rd_entry
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

	entry_t          mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == DepthCnt);
	assign nonempty = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DepthCnt)
		else $error("queue count above depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

// ----- sv/csvt_back.sv -----
// ----------------------------------------------------------------------------
// csvt_back: quote state machine and token output register
// Applies one classified item per cycle to the parser flags, unless the token output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_back
	import csvt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_nonempty,
	input  wire entry_t           q_entry,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [CharW-1:0]      m_tdata,
	output logic [1:0]            m_tuser
);

	logic in_quoted_q, quote_pending_q, field_has_chars_q, row_has_fields_q;
	logic in_quoted_d, quote_pending_d, field_has_chars_d, row_has_fields_d;
	logic unquoted;
	logic emit;
	kind_t kind;
	logic [CharW-1:0] ch_out;
	logic m_valid_q;
	kind_t kind_q;
	logic [CharW-1:0] char_q;

	assign q_pop = q_nonempty && (!m_valid_q || m_tready);

	always_comb begin
		in_quoted_d       = in_quoted_q;
		quote_pending_d   = quote_pending_q;
		field_has_chars_d = field_has_chars_q;
		row_has_fields_d  = row_has_fields_q;
		unquoted          = !in_quoted_q;
		emit              = 1'b0;
		kind              = KIND_CHAR;
		ch_out            = '0;
		if (q_entry.eot) begin
			unquoted          = 1'b0;
			emit              = field_has_chars_q || row_has_fields_q;
			kind              = KIND_ROW_END;
			in_quoted_d       = 1'b0;
			quote_pending_d   = 1'b0;
			field_has_chars_d = 1'b0;
			row_has_fields_d  = 1'b0;
		end else if (in_quoted_q) begin
			if (quote_pending_q) begin
				quote_pending_d = 1'b0;
				if (q_entry.is_quote) begin
					// doubled quote: literal quote character
					field_has_chars_d = 1'b1;
					emit              = 1'b1;
					ch_out            = QUOTE_CH;
				end else begin
					in_quoted_d = 1'b0;
					unquoted    = 1'b1;
				end
			end else if (q_entry.is_quote) begin
				quote_pending_d = 1'b1;
			end else begin
				field_has_chars_d = 1'b1;
				emit              = 1'b1;
				ch_out            = q_entry.ch;
			end
		end
		if (unquoted) begin
			if (q_entry.is_quote) begin
				in_quoted_d = 1'b1;
			end else if (q_entry.is_delim) begin
				field_has_chars_d = 1'b0;
				row_has_fields_d  = 1'b1;
				emit              = 1'b1;
				kind              = KIND_FIELD_END;
			end else if (q_entry.is_cr) begin
				emit = 1'b0;
			end else if (q_entry.is_lf) begin
				field_has_chars_d = 1'b0;
				row_has_fields_d  = 1'b0;
				emit              = 1'b1;
				kind              = KIND_ROW_END;
			end else begin
				field_has_chars_d = 1'b1;
				emit              = 1'b1;
				ch_out            = q_entry.ch;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quoted_q       <= 1'b0;
			quote_pending_q   <= 1'b0;
			field_has_chars_q <= 1'b0;
			row_has_fields_q  <= 1'b0;
			m_valid_q         <= 1'b0;
		end else begin
			if (q_pop) begin
				in_quoted_q       <= in_quoted_d;
				quote_pending_q   <= quote_pending_d;
				field_has_chars_q <= field_has_chars_d;
				row_has_fields_q  <= row_has_fields_d;
			end
			if (q_pop && emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			kind_q <= kind;
			char_q <= ch_out;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = char_q;
	assign m_tuser  = kind_q;

	a_pending_quoted: assert property (@(posedge clk) disable iff (!arst_n)
		quote_pending_q |-> in_quoted_q)
		else $error("quote pending outside quoted mode");

	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_entry.eot) |=>
		(!in_quoted_q && !quote_pending_q && !field_has_chars_q && !row_has_fields_q))
		else $error("end of text left parser flags set");

	a_no_pop_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |-> !q_pop)
		else $error("item consumed while token stalled");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && (kind_q != KIND_CHAR)) |-> (char_q == '0))
		else $error("non-character token carries data");

endmodule

`default_nettype wire

// ----- sv/csv_tokenizer_cp1251.sv -----
// ----------------------------------------------------------------------------
// csv_tokenizer_cp1251: streaming CSV field tokenizer with Windows-1251 decode
// Turns a character stream into field characters, field ends and row ends.
// ----------------------------------------------------------------------------
// Feed one character per transaction on the s_ side (s_tuser = 0) or an
// end-of-text mark (s_tuser = 1, s_tdata ignored). Each transaction yields
// zero or one token on the m_ side: m_tuser 0 is a field character in
// m_tdata, 1 is the end of a field, 2 the end of a field and of a row (data
// zero for both). Quotes follow the usual rules: a quote opens quoted mode,
// a doubled quote inside it is a literal quote, a lone quote closes it
// (resolved on the next character). Outside quotes CR is dropped and LF ends
// the row. The block takes one transaction per clock while the queue has
// room: the front decodes and classifies in the accepting cycle, a
// QueueDepth-entry queue holds classified items, and the back applies one
// item per cycle, unless the output register is stalled, to the quote flags
// into a one-entry output register. s_tready drops only when the queue
// fills under output backpressure.
// Write configuration only while idle: register 0 is the delimiter code
// unit (reset ';'), register 1 enables Windows-1251 decode of the low byte
// (reset off). Writes to other indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_tokenizer_cp1251
	import csvt_pkg::*;
#(
	parameter int unsigned QueueDepth = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write port
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CharW-1:0]   cfg_data,
	// input stream
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [CharW-1:0]   s_tdata,   // [15:0] code
	input  wire logic               s_tuser,   // [0] op: 0 character, 1 end of text
	// output stream
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [CharW-1:0]        m_tdata,   // [15:0] out_char
	output logic [1:0]              m_tuser    // [1:0] kind
);

	logic [CharW-1:0] delimiter_q;
	logic             cp1251_mode_q;
	entry_t           front_entry;
	entry_t           head_entry;
	logic             q_full;
	logic             q_nonempty;
	logic             q_pop;
	logic             accept;

	// Hold configuration; only writes to known indexes take effect.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q   <= DELIM_RESET;
			cp1251_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DELIMITER:   delimiter_q   <= cfg_data;
				REG_CP1251_MODE: cp1251_mode_q <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// Decode and classify each character as it arrives.
	csvt_front u_front (
		.op          (s_tuser),
		.code        (s_tdata),
		.delimiter   (delimiter_q),
		.cp1251_mode (cp1251_mode_q),
		.entry       (front_entry)
	);

	// Buffer classified items so either side can stall on its own.
	csvt_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.wr_entry (front_entry),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rd_entry (head_entry)
	);

	// Advance the quote state and register at most one token per item.
	csvt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_entry    (head_entry),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the CSV tokenizer with cp1251 decode
// Walks a table of directed characters, then generates random delimited text
// (well-formed rows with random content, plus noise and broken quoting)
// under several register settings and idle patterns. Every accepted
// character runs through a local tokenizer model. Every delivered token is
// compared against the oldest predicted token.
// ----------------------------------------------------------------------------
module testbench;
	import csvt_pkg::*;

	localparam int DRAIN_CYCLES = 8;       // queue depth plus pipeline, with margin
	localparam int QUIET_LIMIT = 2000;     // cycles with no transaction on either side
	localparam int HOLD_CYCLES = 80;       // long receiver stall that fills the block
	localparam int RANDOM_PER_SEG = 100;   // six random segments, about 600 items

	// indexes past the register list; writes to them must be ignored
	localparam logic [CfgIdxW-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_UNUSED_3 = 2'd3;

	// idle percentages per phase: sender mostly busy, then receiver, then both never idle
	localparam int SEND_IDLE [3] = '{19, 70, 0};
	localparam int RECV_IDLE [3] = '{70, 19, 0};

	// register settings of the random segments, extremes included
	localparam logic [CharW-1:0] SEG_DELIM [6] =
		'{16'h003B, 16'h002C, 16'h0000, 16'hFFFF, LF_CH, 16'h003B};
	localparam logic SEG_CP1251 [6] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t          rk;
		logic               eot;
		logic [CharW-1:0]   code;      // character code, or register data
		logic               pinned;    // expected token typed in below
		kind_t              pin_kind;
		logic [CharW-1:0]   pin_char;
		logic [CfgIdxW-1:0] idx;
	} dir_row_t;

	typedef struct {
		bit               eot;
		logic [CharW-1:0] code;
		bit               pinned;
		kind_t            pin_kind;
		logic [CharW-1:0] pin_char;
	} text_item_t;

	typedef struct {
		kind_t            kind;
		logic [CharW-1:0] ch;
	} token_t;

	// Directed part. Pinned rows carry a token that is plain from the rules;
	// the rest are checked against the model.
	localparam dir_row_t DIRECTED [34] = '{
		// reset settings: ';' separates, codes pass through unchanged
		'{ROW_ITEM,  1'b0, 16'h0041, 1'b1, KIND_CHAR,      16'h0041, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, 16'hFFFF, 1'b1, KIND_CHAR,      16'hFFFF, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, 16'h003B, 1'b1, KIND_FIELD_END, 16'h0000, REG_DELIMITER},
		// empty quoted field followed by the delimiter
		'{ROW_ITEM,  1'b0, QUOTE_CH, 1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, QUOTE_CH, 1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, 16'h003B, 1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		// quoted CR, doubled quote, then a lone quote closed by CR
		'{ROW_ITEM,  1'b0, QUOTE_CH, 1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, CR_CH,    1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, QUOTE_CH, 1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, QUOTE_CH, 1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, QUOTE_CH, 1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, CR_CH,    1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, LF_CH,    1'b1, KIND_ROW_END,   16'h0000, REG_DELIMITER},
		// end of text on an empty row gives nothing
		'{ROW_ITEM,  1'b1, 16'hFFFF, 1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		// writes past the register list, then cp1251 with CR as delimiter
		'{ROW_WRITE, 1'b0, 16'h002C, 1'b0, KIND_CHAR,      16'h0000, REG_UNUSED_2},
		'{ROW_WRITE, 1'b0, 16'hFFFF, 1'b0, KIND_CHAR,      16'h0000, REG_UNUSED_3},
		'{ROW_WRITE, 1'b0, 16'h0001, 1'b0, KIND_CHAR,      16'h0000, REG_CP1251_MODE},
		'{ROW_WRITE, 1'b0, CR_CH,    1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, 16'h0080, 1'b1, KIND_CHAR,      16'h0402, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, 16'hAB98, 1'b1, KIND_CHAR,      16'hFFFD, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, 16'h009F, 1'b1, KIND_CHAR,      16'hFFFD, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, 16'hFFC0, 1'b1, KIND_CHAR,      16'h0410, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, 16'hFF0D, 1'b1, KIND_FIELD_END, 16'h0000, REG_DELIMITER},
		// pending quote at end of text just closes; the row had fields
		'{ROW_ITEM,  1'b0, QUOTE_CH, 1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, 16'h5A22, 1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b1, 16'h1234, 1'b1, KIND_ROW_END,   16'h0000, REG_DELIMITER},
		// delimiter set to the quote: the quote still opens quoted mode
		'{ROW_WRITE, 1'b0, 16'h0000, 1'b0, KIND_CHAR,      16'h0000, REG_CP1251_MODE},
		'{ROW_WRITE, 1'b0, QUOTE_CH, 1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, QUOTE_CH, 1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, 16'h0071, 1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b1, 16'h0000, 1'b1, KIND_ROW_END,   16'h0000, REG_DELIMITER},
		// delimiter set to LF: LF only ends the field
		'{ROW_WRITE, 1'b0, LF_CH,    1'b0, KIND_CHAR,      16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b0, LF_CH,    1'b1, KIND_FIELD_END, 16'h0000, REG_DELIMITER},
		'{ROW_ITEM,  1'b1, 16'h0000, 1'b1, KIND_ROW_END,   16'h0000, REG_DELIMITER}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = REG_DELIMITER;
	logic [CharW-1:0]   cfg_data = '0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [CharW-1:0]   s_tdata = '0;   // [15:0] code
	logic               s_tuser = 1'b0; // [0] op: 0 character, 1 end of text
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [CharW-1:0]   m_tdata;        // [15:0] out_char
	logic [1:0]         m_tuser;        // [1:0] kind

	csv_tokenizer_cp1251 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #4 clk = ~clk;

	// Local copy of the registers and of the tokenizer flags.
	logic [CharW-1:0] cfg_delim = DELIM_RESET;
	logic             cfg_cp1251 = 1'b0;
	bit               in_quote, quote_held, field_open, row_open;

	text_item_t text_q [$];      // characters waiting to be offered
	token_t     tokens_due [$];  // predicted tokens, oldest first
	text_item_t cur_item;
	token_t     got_due;
	kind_t      pred_kind;
	logic [CharW-1:0] pred_char;

	int items_pending = 0;       // queued but not yet accepted
	int fail_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int idle_phase = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int quiet_cycles = 0;

	// Map an input code to the character the tokenizer sees.
	function automatic logic [CharW-1:0] decode_code(input logic [CharW-1:0] code);
		if (!cfg_cp1251)
			return code;
		if (!code[7])
			return {8'h00, code[7:0]};
		return CP1251_HI[code[6:0]];
	endfunction

	// Advance the tokenizer flags by one transaction; return 1 when a token
	// comes out, with its kind and character.
	function automatic bit tokenize(input bit eot, input logic [CharW-1:0] code,
			output kind_t kind, output logic [CharW-1:0] ch);
		logic [CharW-1:0] c;
		bit               row_end;
		kind = KIND_CHAR;
		ch = '0;
		if (eot) begin
			// a row end only if something of the row is still open
			row_end = field_open || row_open;
			kind = KIND_ROW_END;
			in_quote = 1'b0;
			quote_held = 1'b0;
			field_open = 1'b0;
			row_open = 1'b0;
			return row_end;
		end
		c = decode_code(code);
		if (in_quote) begin
			if (quote_held) begin
				quote_held = 1'b0;
				if (c == QUOTE_CH) begin
					field_open = 1'b1;
					ch = QUOTE_CH;
					return 1'b1;
				end
				// lone quote: leave quoted mode, then treat c as unquoted
				in_quote = 1'b0;
			end else if (c == QUOTE_CH) begin
				quote_held = 1'b1;
				return 1'b0;
			end else begin
				field_open = 1'b1;
				ch = c;
				return 1'b1;
			end
		end
		// the quote is checked first, the delimiter before CR and LF
		if (c == QUOTE_CH) begin
			in_quote = 1'b1;
			return 1'b0;
		end
		if (c == cfg_delim) begin
			field_open = 1'b0;
			row_open = 1'b1;
			kind = KIND_FIELD_END;
			return 1'b1;
		end
		if (c == CR_CH)
			return 1'b0;
		if (c == LF_CH) begin
			field_open = 1'b0;
			row_open = 1'b0;
			kind = KIND_ROW_END;
			return 1'b1;
		end
		field_open = 1'b1;
		ch = c;
		return 1'b1;
	endfunction

	function automatic void queue_item(input bit eot, input logic [CharW-1:0] code,
			input bit pinned = 1'b0, input kind_t pin_kind = KIND_CHAR,
			input logic [CharW-1:0] pin_char = '0);
		text_item_t it;
		it.eot = eot;
		it.code = code;
		it.pinned = pinned;
		it.pin_kind = pin_kind;
		it.pin_char = pin_char;
		text_q.push_back(it);
		items_pending++;
	endfunction

	// ASCII character as a code; in cp1251 mode put noise in the high byte.
	function automatic logic [CharW-1:0] ascii_code(input logic [CharW-1:0] ch);
		if (cfg_cp1251 && ch < 16'h0080)
			return {8'($urandom), ch[7:0]};
		return ch;
	endfunction

	// Random field content that is neither quote, delimiter, CR nor LF.
	function automatic logic [CharW-1:0] content_code();
		logic [CharW-1:0] c;
		logic [CharW-1:0] d;
		do begin
			if ($urandom_range(1) == 0)
				c = ascii_code(16'($urandom_range(32, 126)));
			else
				c = 16'($urandom);
			d = decode_code(c);
		end while (d == QUOTE_CH || d == cfg_delim || d == CR_CH || d == LF_CH);
		return c;
	endfunction

	// Build rows of random fields, some quoted, mixed with noise and
	// broken quoting, until about n characters are queued.
	function automatic void gen_text(input int n);
		int start;
		int nfields;
		int len;
		int style;
		int pick;
		start = items_pending;
		while (items_pending - start < n) begin
			if ($urandom_range(99) < 10) begin
				queue_item($urandom_range(9) == 0, 16'($urandom));
				continue;
			end
			nfields = $urandom_range(1, 4);
			for (int f = 0; f < nfields; f++) begin
				if (f != 0)
					queue_item(1'b0, ascii_code(cfg_delim));
				style = $urandom_range(9);
				if (style < 6) begin
					len = $urandom_range(0, 4);
					for (int k = 0; k < len; k++)
						queue_item(1'b0, content_code());
				end else begin
					queue_item(1'b0, ascii_code(QUOTE_CH));
					len = $urandom_range(0, 4);
					for (int k = 0; k < len; k++) begin
						pick = $urandom_range(7);
						case (pick)
							0: queue_item(1'b0, ascii_code(cfg_delim));
							1: queue_item(1'b0, ascii_code(CR_CH));
							2: queue_item(1'b0, ascii_code(LF_CH));
							3: begin
								queue_item(1'b0, ascii_code(QUOTE_CH));
								queue_item(1'b0, ascii_code(QUOTE_CH));
							end
							default: queue_item(1'b0, content_code());
						endcase
					end
					// drop the closing quote now and then: text stays quoted
					if (style != 9 || $urandom_range(1) == 0)
						queue_item(1'b0, ascii_code(QUOTE_CH));
					// one trailing character after the closing quote, if any
					if (style == 9)
						queue_item(1'b0, content_code());
				end
			end
			pick = $urandom_range(9);
			if (pick < 5) begin
				queue_item(1'b0, ascii_code(LF_CH));
			end else if (pick < 8) begin
				queue_item(1'b0, ascii_code(CR_CH));
				queue_item(1'b0, ascii_code(LF_CH));
			end else if (pick < 9) begin
				queue_item(1'b1, 16'($urandom));
			end
		end
	endfunction

	// Write one register and mirror it in the model.
	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CharW-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DELIMITER)
			cfg_delim = data;
		else if (idx == REG_CP1251_MODE)
			cfg_cp1251 = data[0];
	endtask

	// Wait until every character is taken and every token delivered, then
	// let dropped characters still in the pipeline drain out.
	task automatic settle();
		while (items_pending != 0 || tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Sender: predict on each accepted transaction, then offer the next
	// character or idle. Sampling happens at the edge, before any update.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				items_pending--;
				if (tokenize(cur_item.eot, cur_item.code, pred_kind, pred_char) &&
						!cur_item.pinned)
					tokens_due.push_back(token_t'{pred_kind, pred_char});
				if (cur_item.pinned)
					tokens_due.push_back(token_t'{cur_item.pin_kind, cur_item.pin_char});
			end
			if (!s_tvalid || s_tready) begin
				if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_item = text_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur_item.code;
					s_tuser <= cur_item.eot;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each delivered token against the oldest prediction,
	// then pick the ready level for the next cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (tokens_due.size() == 0) begin
					$error("unexpected token: kind %0d, out_char 0x%04h", m_tuser, m_tdata);
					fail_count++;
				end else begin
					got_due = tokens_due.pop_front();
					if (m_tuser !== got_due.kind) begin
						$error("kind: expected %0d, actual %0d", got_due.kind, m_tuser);
						fail_count++;
					end
					if (m_tdata !== got_due.ch) begin
						$error("out_char: expected 0x%04h, actual 0x%04h", got_due.ch, m_tdata);
						fail_count++;
					end
				end
			end
			// one long stall while the sender streams with no gaps, so the
			// internal queue fills and s_tready drops
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && idle_phase == 2 && m_tvalid) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: end the run when no transaction happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = SEND_IDLE[0];
		recv_idle_pct = RECV_IDLE[0];

		// directed table; registers change only once the block is idle
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].rk == ROW_WRITE) begin
				settle();
				write_reg(DIRECTED[i].idx, DIRECTED[i].code);
			end else begin
				queue_item(DIRECTED[i].eot, DIRECTED[i].code, DIRECTED[i].pinned,
					DIRECTED[i].pin_kind, DIRECTED[i].pin_char);
			end
		end

		// random text: two segments per idle phase, each with new settings
		for (int seg = 0; seg < 6; seg++) begin
			settle();
			idle_phase = seg / 2;
			send_idle_pct = SEND_IDLE[idle_phase];
			recv_idle_pct = RECV_IDLE[idle_phase];
			write_reg(REG_DELIMITER, SEG_DELIM[seg]);
			write_reg(REG_CP1251_MODE, {15'd0, SEG_CP1251[seg]});
			gen_text(RANDOM_PER_SEG);
		end
		settle();

		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
